>>> hw/rtl/derivative_pulse_peak_finder_top_assert.svh
// assertion macros for the derivative pulse peak finder
`ifndef DERIVATIVE_PULSE_PEAK_FINDER_TOP_ASSERT_SVH
`define DERIVATIVE_PULSE_PEAK_FINDER_TOP_ASSERT_SVH

// clocked check, quiet while reset is high
`define DPPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define DPPF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/dppf_pkg.sv
// shared constants for the derivative pulse peak finder
package dppf_pkg;

   localparam int SAMPLE_BITS_DEF  = 12;
   localparam int MAX_RECORD_DEF   = 4096;
   localparam int THRESH_BITS      = 14;
   localparam int INDEX_OUT_BITS   = 12;
   localparam int COUNT_BITS       = 11;
   localparam int DERIV_DIVISOR    = 12;

   localparam logic signed [THRESH_BITS-1:0] THRESH_RESET = -14'sd11;
   localparam logic [COUNT_BITS-1:0]         COUNT_MAX    = {COUNT_BITS{1'b1}};

endpackage

>>> hw/rtl/derivative_pulse_peak_finder_top.sv
// derivative pulse peak finder: five-point slope, peak tracking and result register
`include "derivative_pulse_peak_finder_top_assert.svh"

// Samples of one record stream in on req_ (req_last on the final sample) and one beat is taken
// per clock while the result path does not stall. Each beat is held in an input register; the
// slope, the peak rules and the state update then run combinationally into the result register,
// and throughput is one sample per clock, limited only by the five-point slope and threshold
// compare between those two registers. The result register is freed in the same cycle that
// rsp_ready takes its beat, so a stalled consumer blocks the input only once both registers
// hold data. A result beat is sent when a peak completes or on the last sample (rsp_record_end),
// or both at once; a peak still open at record end is dropped. csr_data sets the signed slope
// threshold, which the user must write only while the block is idle; the block does not enforce it.
module derivative_pulse_peak_finder_top #(
   parameter int SAMPLE_BITS = dppf_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_RECORD  = dppf_pkg::MAX_RECORD_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [SAMPLE_BITS-1:0]                      req_sample,
   input  logic                                        req_last,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic                                        rsp_peak_valid,
   output logic [dppf_pkg::INDEX_OUT_BITS-1:0]         rsp_peak_start,
   output logic [dppf_pkg::INDEX_OUT_BITS-1:0]         rsp_peak_end,
   output logic [dppf_pkg::INDEX_OUT_BITS-1:0]         rsp_peak_min_index,
   output logic [SAMPLE_BITS-1:0]                      rsp_peak_min_value,
   output logic                                        rsp_record_end,
   output logic [dppf_pkg::COUNT_BITS-1:0]             rsp_peak_count,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic signed [dppf_pkg::THRESH_BITS-1:0]     csr_data
);

   localparam int IW = $clog2(MAX_RECORD);
   localparam int OB = dppf_pkg::INDEX_OUT_BITS;
   localparam int TB = dppf_pkg::THRESH_BITS;
   localparam int NW = SAMPLE_BITS + 5;
   localparam int TW = TB + 4;
   localparam int CW = (NW > TW) ? NW : TW;
   localparam logic [IW-1:0] IDX_MAX = IW'(MAX_RECORD - 1);
   localparam logic signed [CW-1:0] DIV_S = CW'(dppf_pkg::DERIV_DIVISOR);

   // input register
   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                   s1_last_ff;

   // record state
   logic [SAMPLE_BITS-1:0]           win_ff [4];
   logic [SAMPLE_BITS-1:0]           win_in [4];
   logic [IW-1:0]                    idx_ff, idx_in;
   logic                             in_peak_ff, in_peak_in;
   logic                             rising_ff, rising_in;
   logic [IW-1:0]                    start_ff, start_in;
   logic [IW-1:0]                    min_idx_ff, min_idx_in;
   logic [SAMPLE_BITS-1:0]           min_val_ff, min_val_in;
   logic [dppf_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic signed [TB-1:0]             thresh_ff;

   // result register
   logic                             out_valid_ff, out_valid_in;
   logic                             out_peak_ff;
   logic [IW-1:0]                    out_start_ff, out_end_ff, out_min_idx_ff;
   logic [SAMPLE_BITS-1:0]           out_min_val_ff;
   logic                             out_rec_end_ff;
   logic [dppf_pkg::COUNT_BITS-1:0]  out_count_ff;

   logic                             advance, req_accept, emit, done;
   logic [IW-1:0]                    r_start, r_end, r_min_idx;
   logic [SAMPLE_BITS-1:0]           r_min_val;
   logic signed [CW-1:0]             xs, w0s, w2s, w3s, num_raw, num_eff, thr_s, thr12;
   logic                             d_neg, d_pos, below, active;
   logic [IW-1:0]                    cur_i;

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign emit         = done || s1_last_ff;
   assign out_valid_in = advance ? emit : (out_valid_ff && !rsp_ready);

   always_comb begin
      xs      = signed'(CW'(s1_sample_ff));
      w0s     = signed'(CW'(win_ff[0]));
      w2s     = signed'(CW'(win_ff[2]));
      w3s     = signed'(CW'(win_ff[3]));
      num_raw = w3s + (w0s <<< 3) - (w2s <<< 3) - xs;
      num_eff = (idx_ff >= IW'(4)) ? num_raw : '0;
      thr_s   = CW'(thresh_ff);
      thr12   = (thr_s <<< 3) + (thr_s <<< 2);
      // truncated slope compared by scaling the threshold instead of dividing
      d_neg   = num_eff <= -DIV_S;
      d_pos   = num_eff >= DIV_S;
      below   = (!thresh_ff[TB-1] && (thresh_ff != '0)) ? (num_eff < thr12)
                                                          : (num_eff <= thr12 - DIV_S);
      active  = idx_ff >= IW'(2);
      cur_i   = idx_ff - IW'(2);

      done       = 1'b0;
      r_start    = '0;
      r_end      = '0;
      r_min_idx  = '0;
      r_min_val  = '0;
      in_peak_in = in_peak_ff;
      rising_in  = rising_ff;
      start_in   = start_ff;
      min_idx_in = min_idx_ff;
      min_val_in = min_val_ff;
      count_in   = count_ff;

      if (active) begin
         if (in_peak_in && rising_in && d_neg) begin
            done       = 1'b1;
            r_start    = start_ff;
            r_end      = cur_i;
            r_min_idx  = min_idx_ff;
            r_min_val  = min_val_ff;
            if (count_ff != dppf_pkg::COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            in_peak_in = 1'b0;
            rising_in  = 1'b0;
            start_in   = '0;
            min_idx_in = '0;
            min_val_in = '0;
         end
         if (in_peak_in && !rising_in && d_pos) begin
            rising_in = 1'b1;
         end
         if (!in_peak_in && below) begin
            in_peak_in = 1'b1;
            start_in   = cur_i;
            min_idx_in = cur_i;
            min_val_in = win_ff[1];
         end
         if (in_peak_in && (win_ff[1] < min_val_in)) begin
            min_idx_in = cur_i;
            min_val_in = win_ff[1];
         end
      end

      win_in[3] = win_ff[2];
      win_in[2] = win_ff[1];
      win_in[1] = win_ff[0];
      win_in[0] = s1_sample_ff;
      idx_in    = (idx_ff != IDX_MAX) ? idx_ff + 1'b1 : idx_ff;

      if (s1_last_ff) begin
         win_in     = '{default: '0};
         idx_in     = '0;
         in_peak_in = 1'b0;
         rising_in  = 1'b0;
         start_in   = '0;
         min_idx_in = '0;
         min_val_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         thresh_ff    <= dppf_pkg::THRESH_RESET;
         win_ff       <= '{default: '0};
         idx_ff       <= '0;
         in_peak_ff   <= 1'b0;
         rising_ff    <= 1'b0;
         start_ff     <= '0;
         min_idx_ff   <= '0;
         min_val_ff   <= '0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            thresh_ff <= csr_data;
         end
         if (advance) begin
            win_ff     <= win_in;
            idx_ff     <= idx_in;
            in_peak_ff <= in_peak_in;
            rising_ff  <= rising_in;
            start_ff   <= start_in;
            min_idx_ff <= min_idx_in;
            min_val_ff <= min_val_in;
            count_ff   <= s1_last_ff ? '0 : count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_sample;
         s1_last_ff   <= req_last;
      end
      if (advance && emit) begin
         out_peak_ff    <= done;
         out_start_ff   <= r_start;
         out_end_ff     <= r_end;
         out_min_idx_ff <= r_min_idx;
         out_min_val_ff <= r_min_val;
         out_rec_end_ff <= s1_last_ff;
         out_count_ff   <= count_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_peak_valid     = out_peak_ff;
   assign rsp_peak_start     = OB'(out_start_ff);
   assign rsp_peak_end       = OB'(out_end_ff);
   assign rsp_peak_min_index = OB'(out_min_idx_ff);
   assign rsp_peak_min_value = out_min_val_ff;
   assign rsp_record_end     = out_rec_end_ff;
   assign rsp_peak_count     = out_count_ff;

   // a beat always reports a peak, a record end or both
   `DPPF_ASSERT(a_beat_has_cause, clock, reset, rsp_valid |-> (rsp_peak_valid || rsp_record_end), "result beat with neither peak nor record end")
   // fields of a beat without a peak read as zero
   `DPPF_ASSERT(a_no_peak_zero, clock, reset, (rsp_valid && !rsp_peak_valid) |-> (rsp_peak_start == '0 && rsp_peak_min_value == '0), "peak fields not zero on a record end beat")
   // the last sample leaves the record state cleared
   `DPPF_ASSERT(a_last_clears, clock, reset, (advance && s1_last_ff) |=> (idx_ff == '0 && !in_peak_ff && count_ff == '0), "record state not cleared after last sample")
   // rising only ever set inside a peak
   `DPPF_ASSERT_ALWAYS(a_rising_in_peak, clock, rising_ff |-> in_peak_ff, "rising set outside a peak")

endmodule
